[src/arm_pkg.sv]
// ----------------------------------------------------------------------------
// arm_pkg: shared types and constants for the address range mode table
// Holds the default sizes, command codes and the operation code that the
// controller sends along the row of entry cells.
// ----------------------------------------------------------------------------
package arm_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned AddrBits     = 48;
  localparam int unsigned ModeBits     = 16;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_GET   = 2'd2;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_GET   = 2'd2,
    OP_PLACE = 2'd3
  } cell_op_t;

endpackage

[src/address_range_mode_table.sv]
// ----------------------------------------------------------------------------
// address_range_mode_table: table of address ranges with mode bits
// Sequencer over a row of entry cells that applies set, clear and get.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: command,
//   range_low, range_high, mode_bits. Output channel (out_valid / out_stall)
//   returns one word per command: mode_union and table_full.
//   The block works on one command at a time. A clear walks the cells one
//   per cycle and then goes to the done state; a set walks the cells the
//   same way and adds a place step for the new range; a get reads all
//   cells at once. Unknown commands go straight to the done state.
//   The walk over the cells, one entry per cycle, sets the clear and set time:
//   a right remainder of an entry must see the free cells left by all lower
//   entries before it is placed.
//   in_stall is high while a command is in flight. A finished result waits
//   in the output register while out_stall is high; the next command may
//   be accepted meanwhile but its result holds until the register is taken.
//   Reset frees every entry and empties the output register.
// ----------------------------------------------------------------------------
module address_range_mode_table #(
  parameter int unsigned TABLE_ENTRIES = arm_pkg::TableEntries,
  parameter int unsigned ADDR_BITS     = arm_pkg::AddrBits,
  parameter int unsigned MODE_BITS     = arm_pkg::ModeBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [ADDR_BITS-1:0] range_low,
  input  logic [ADDR_BITS-1:0] range_high,
  input  logic [MODE_BITS-1:0] mode_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MODE_BITS-1:0] mode_union,
  output logic                 table_full
);

  localparam int unsigned IdxBits = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_GET   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t               st;
  state_t               st_next;
  logic [1:0]           cmd;
  logic [ADDR_BITS-1:0] lo;
  logic [ADDR_BITS-1:0] hi;
  logic [MODE_BITS-1:0] mode;
  logic [IdxBits-1:0]   idx;
  logic                 full_acc;
  logic [MODE_BITS-1:0] uni_acc;
  logic                 idx_last;
  logic                 in_fire;
  logic                 out_free;

  arm_pkg::cell_op_t    op;
  logic                 bc_need;
  logic [ADDR_BITS-1:0] bc_start;
  logic [ADDR_BITS-1:0] bc_end;
  logic [MODE_BITS-1:0] bc_mode;

  logic [TABLE_ENTRIES:0] taken_ch;
  logic [TABLE_ENTRIES:0] need_ch;
  logic [ADDR_BITS-1:0]   start_ch [TABLE_ENTRIES+1];
  logic [ADDR_BITS-1:0]   end_ch   [TABLE_ENTRIES+1];
  logic [MODE_BITS-1:0]   mode_ch  [TABLE_ENTRIES+1];
  logic [MODE_BITS-1:0]   uni_ch   [TABLE_ENTRIES+1];

  assign in_stall = (st != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx_last = (idx == IdxBits'(TABLE_ENTRIES - 1));

  always_comb begin
    unique case (st)
      ST_CLEAR: op = arm_pkg::OP_CLEAR;
      ST_PLACE: op = arm_pkg::OP_PLACE;
      ST_GET:   op = arm_pkg::OP_GET;
      default:  op = arm_pkg::OP_NONE;
    endcase
  end

  // during a clear the split piece comes off the end of the row
  always_comb begin
    if (st == ST_PLACE) begin
      bc_need  = 1'b1;
      bc_start = lo;
      bc_end   = hi;
      bc_mode  = mode;
    end else begin
      bc_need  = need_ch[TABLE_ENTRIES];
      bc_start = start_ch[TABLE_ENTRIES];
      bc_end   = end_ch[TABLE_ENTRIES];
      bc_mode  = mode_ch[TABLE_ENTRIES];
    end
  end

  assign taken_ch[0] = 1'b0;
  assign need_ch[0]  = 1'b0;
  assign start_ch[0] = '0;
  assign end_ch[0]   = '0;
  assign mode_ch[0]  = '0;
  assign uni_ch[0]   = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arm_cell #(
      .ADDR_BITS(ADDR_BITS),
      .MODE_BITS(MODE_BITS),
      .IDX_BITS (IdxBits),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .scan_idx    (idx),
      .lo          (lo),
      .hi          (hi),
      .bc_need     (bc_need),
      .bc_start    (bc_start),
      .bc_end      (bc_end),
      .bc_mode     (bc_mode),
      .taken_in    (taken_ch[g]),
      .taken_out   (taken_ch[g+1]),
      .pc_need_in  (need_ch[g]),
      .pc_start_in (start_ch[g]),
      .pc_end_in   (end_ch[g]),
      .pc_mode_in  (mode_ch[g]),
      .pc_need_out (need_ch[g+1]),
      .pc_start_out(start_ch[g+1]),
      .pc_end_out  (end_ch[g+1]),
      .pc_mode_out (mode_ch[g+1]),
      .uni_in      (uni_ch[g]),
      .uni_out     (uni_ch[g+1])
    );
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (in_fire) begin
          if (command == arm_pkg::CMD_SET || command == arm_pkg::CMD_CLEAR) begin
            st_next = ST_CLEAR;
          end else if (command == arm_pkg::CMD_GET) begin
            st_next = ST_GET;
          end else begin
            st_next = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        if (idx_last) begin
          st_next = (cmd == arm_pkg::CMD_SET) ? ST_PLACE : ST_DONE;
        end
      end
      ST_PLACE: st_next = ST_DONE;
      ST_GET:   st_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          st_next = ST_IDLE;
        end
      end
      default:  st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd      <= command;
      lo       <= range_low;
      hi       <= range_high;
      mode     <= mode_bits;
      idx      <= '0;
      full_acc <= 1'b0;
      uni_acc  <= '0;
    end else begin
      if (st == ST_CLEAR) begin
        idx <= idx + IdxBits'(1);
        // drop a remainder with nowhere to go
        if (bc_need && !taken_ch[TABLE_ENTRIES]) begin
          full_acc <= 1'b1;
        end
      end
      if (st == ST_PLACE && !taken_ch[TABLE_ENTRIES]) begin
        full_acc <= 1'b1;
      end
      if (st == ST_GET) begin
        uni_acc <= uni_ch[TABLE_ENTRIES];
      end
    end
    if (st == ST_DONE && out_free) begin
      mode_union <= uni_acc;
      table_full <= full_acc;
    end
  end

  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(table_full && mode_union != '0))
    else $error("result carries both a mode union and a full flag");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_stall)
    else $error("input not stalled after a command was taken");

  a_scan_runs: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CLEAR && !idx_last) |=> (st == ST_CLEAR))
    else $error("cell walk ended early");

  a_walk_ordered: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CLEAR && !idx_last) |=> (idx == $past(idx) + IdxBits'(1)))
    else $error("cell index skipped");

endmodule

[src/arm_cell.sv]
// ----------------------------------------------------------------------------
// arm_cell: one entry of the address range mode table
// Holds one range and its mode, cuts the command range out of it when its
// index comes up, and claims a broadcast piece when it is the first free cell.
// ----------------------------------------------------------------------------
module arm_cell #(
  parameter int unsigned ADDR_BITS = arm_pkg::AddrBits,
  parameter int unsigned MODE_BITS = arm_pkg::ModeBits,
  parameter int unsigned IDX_BITS  = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  arm_pkg::cell_op_t    op,
  input  logic [IDX_BITS-1:0]  scan_idx,
  input  logic [ADDR_BITS-1:0] lo,
  input  logic [ADDR_BITS-1:0] hi,
  // piece broadcast back to all cells
  input  logic                 bc_need,
  input  logic [ADDR_BITS-1:0] bc_start,
  input  logic [ADDR_BITS-1:0] bc_end,
  input  logic [MODE_BITS-1:0] bc_mode,
  // chains from the lower neighbor
  input  logic                 taken_in,
  output logic                 taken_out,
  input  logic                 pc_need_in,
  input  logic [ADDR_BITS-1:0] pc_start_in,
  input  logic [ADDR_BITS-1:0] pc_end_in,
  input  logic [MODE_BITS-1:0] pc_mode_in,
  output logic                 pc_need_out,
  output logic [ADDR_BITS-1:0] pc_start_out,
  output logic [ADDR_BITS-1:0] pc_end_out,
  output logic [MODE_BITS-1:0] pc_mode_out,
  input  logic [MODE_BITS-1:0] uni_in,
  output logic [MODE_BITS-1:0] uni_out
);

  logic [ADDR_BITS-1:0] s;
  logic [ADDR_BITS-1:0] e;
  logic [MODE_BITS-1:0] m;
  logic [ADDR_BITS-1:0] s_next;
  logic [ADDR_BITS-1:0] e_next;
  logic [MODE_BITS-1:0] m_next;

  logic                 is_free;
  logic                 hit;
  logic [ADDR_BITS-1:0] ov_lo;
  logic [ADDR_BITS-1:0] ov_hi;
  logic                 left_rem;
  logic                 right_rem;
  logic                 sel;
  logic                 take;
  logic                 split;

  assign is_free   = (m == '0);
  assign ov_lo     = (lo > s) ? lo : s;
  assign ov_hi     = (hi < e) ? hi : e;
  assign hit       = !is_free && !(s > hi || lo > e) && (ov_lo != '0) && (ov_hi != '0);
  assign left_rem  = (ov_lo != s);
  assign right_rem = (ov_hi != e);
  assign sel       = (op == arm_pkg::OP_CLEAR) && (scan_idx == IDX_BITS'(CELL_IDX));
  assign split     = sel && hit && left_rem && right_rem;

  // first free cell in the row takes the piece
  assign take      = (op == arm_pkg::OP_CLEAR || op == arm_pkg::OP_PLACE) &&
                     bc_need && is_free && !taken_in;
  assign taken_out = taken_in || take;

  assign pc_need_out  = pc_need_in || split;
  assign pc_start_out = pc_start_in | (split ? ov_hi + ADDR_BITS'(1) : '0);
  assign pc_end_out   = pc_end_in | (split ? e : '0);
  assign pc_mode_out  = pc_mode_in | (split ? m : '0);

  assign uni_out = uni_in | ((op == arm_pkg::OP_GET && hit) ? m : '0);

  always_comb begin
    s_next = s;
    e_next = e;
    m_next = m;
    if (sel && hit) begin
      if (left_rem) begin
        e_next = ov_lo - ADDR_BITS'(1);
      end else if (right_rem) begin
        s_next = ov_hi + ADDR_BITS'(1);
      end else begin
        m_next = '0;
      end
    end else if (take) begin
      s_next = bc_start;
      e_next = bc_end;
      m_next = bc_mode;
    end
  end

  always_ff @(posedge clk) begin
    s <= s_next;
    e <= e_next;
    if (rst) begin
      m <= '0;
    end else begin
      m <= m_next;
    end
  end

endmodule

[test/address_range_mode_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_mode_table_tb: self-checking bench for the range mode table
// Drives set, clear, get and unknown commands with random gaps on both sides, keeps
// its own copy of the table to predict mode_union and table_full, and
// compares every returned word in order against the predicted one.
// ----------------------------------------------------------------------------
module address_range_mode_table_tb;

  localparam int Slots = arm_pkg::TableEntries;
  localparam int AddrW = arm_pkg::AddrBits;
  localparam int ModeW = arm_pkg::ModeBits;
  localparam logic [1:0] CmdBad = 2'd3;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [ModeW-1:0] mode_t;
  typedef struct packed {
    mode_t modes;
    logic  full;
  } outcome_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] command;
  addr_t range_low, range_high;
  mode_t mode_bits;
  logic out_valid, out_stall;
  mode_t mode_union;
  logic table_full;

  address_range_mode_table dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .range_low(range_low), .range_high(range_high),
    .mode_bits(mode_bits), .out_valid(out_valid), .out_stall(out_stall),
    .mode_union(mode_union), .table_full(table_full)
  );

  addr_t    tbl_lo [Slots];
  addr_t    tbl_hi [Slots];
  mode_t    tbl_mode [Slots];
  outcome_t pending_words [$];
  int       errors = 0;
  int       cycles = 0;
  bit       hold_off = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int first_free();
    for (int i = 0; i < Slots; i++)
      if (tbl_mode[i] == '0) return i;
    return -1;
  endfunction

  function automatic bit hits(int i, addr_t lo, addr_t hi, output addr_t olo,
                              output addr_t ohi);
    if (tbl_lo[i] > hi || lo > tbl_hi[i]) return 0;
    olo = (lo > tbl_lo[i]) ? lo : tbl_lo[i];
    ohi = (hi < tbl_hi[i]) ? hi : tbl_hi[i];
    return olo != '0 && ohi != '0;
  endfunction

  function automatic bit cut_range(addr_t lo, addr_t hi);
    bit full = 0;
    for (int i = 0; i < Slots; i++) begin
      addr_t olo, ohi, s, e;
      mode_t m;
      bit reused;
      int slot;
      reused = 0;
      if (tbl_mode[i] == '0) continue;
      if (!hits(i, lo, hi, olo, ohi)) continue;
      s = tbl_lo[i]; e = tbl_hi[i]; m = tbl_mode[i];
      tbl_lo[i] = '0; tbl_hi[i] = '0; tbl_mode[i] = '0;
      if (olo != s) begin
        tbl_lo[i] = s; tbl_hi[i] = olo - 1'b1; tbl_mode[i] = m;
        reused = 1;
      end
      if (ohi != e) begin
        slot = reused ? first_free() : i;
        if (slot < 0) full = 1;
        else begin
          tbl_lo[slot] = ohi + 1'b1; tbl_hi[slot] = e; tbl_mode[slot] = m;
        end
      end
    end
    return full;
  endfunction

  function automatic outcome_t apply_command(logic [1:0] cmd, addr_t lo, addr_t hi,
                                             mode_t m);
    outcome_t r;
    int slot;
    addr_t olo, ohi;
    r = '0;
    if (cmd == arm_pkg::CMD_SET) begin
      r.full = cut_range(lo, hi);
      slot = first_free();
      if (slot < 0) r.full = 1;
      else begin
        tbl_lo[slot] = lo; tbl_hi[slot] = hi; tbl_mode[slot] = m;
      end
    end else if (cmd == arm_pkg::CMD_CLEAR) begin
      r.full = cut_range(lo, hi);
    end else if (cmd == arm_pkg::CMD_GET) begin
      for (int i = 0; i < Slots; i++)
        if (tbl_mode[i] != '0 && hits(i, lo, hi, olo, ohi)) r.modes |= tbl_mode[i];
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // predict at send time: commands are accepted in order; valid stays high
  // after the accept, so the caller drops it when no word follows at once
  task automatic send_word(logic [1:0] cmd, addr_t lo, addr_t hi, mode_t m);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; command <= cmd; range_low <= lo; range_high <= hi; mode_bits <= m;
    do @(posedge clk); while (in_stall);
    pending_words.push_back(apply_command(cmd, lo, hi, m));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word union=%h full=%b", $time, mode_union, table_full);
        errors++;
      end else begin
        outcome_t w;
        w = pending_words.pop_front();
        if (w.modes !== mode_union) begin
          $display("%0t: mode_union expected %h actual %h", $time, w.modes, mode_union);
          errors++;
        end
        if (w.full !== table_full) begin
          $display("%0t: table_full expected %b actual %b", $time, w.full, table_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  function automatic addr_t rand_addr();
    return addr_t'({$urandom(), $urandom()});
  endfunction

  // small window so ranges collide often
  function automatic addr_t near_addr();
    return addr_t'($urandom_range(0, 64));
  endfunction

  task automatic test_directed();
    addr_t top;
    top = '1;
    send_word(arm_pkg::CMD_GET, '0, top, '0);
    send_word(arm_pkg::CMD_SET, addr_t'(10), addr_t'(20), 16'h0001);
    send_word(arm_pkg::CMD_SET, addr_t'(15), addr_t'(30), 16'h8000);
    send_word(arm_pkg::CMD_GET, '0, top, '0);
    send_word(arm_pkg::CMD_CLEAR, addr_t'(12), addr_t'(13), '0);
    send_word(arm_pkg::CMD_GET, addr_t'(12), addr_t'(12), '0);
    send_word(arm_pkg::CMD_SET, '0, addr_t'(5), 16'hffff);
    send_word(arm_pkg::CMD_GET, '0, '0, '0);
    send_word(arm_pkg::CMD_SET, top - addr_t'(5), top, 16'h5a5a);
    send_word(arm_pkg::CMD_GET, top, top, '0);
    send_word(arm_pkg::CMD_SET, addr_t'(40), addr_t'(30), 16'h0002);
    send_word(arm_pkg::CMD_GET, addr_t'(35), addr_t'(35), '0);
    send_word(arm_pkg::CMD_SET, addr_t'(22), addr_t'(24), 16'h0000);
    send_word(arm_pkg::CMD_GET, addr_t'(20), addr_t'(25), '0);
    send_word(CmdBad, addr_t'(1), addr_t'(2), 16'h0004);
    send_word(arm_pkg::CMD_CLEAR, '0, top, '0);
    send_word(arm_pkg::CMD_GET, addr_t'(1), top, '0);
  endtask

  // punch a hole into every entry of a full table so no split piece finds a slot
  task automatic test_table_full();
    for (int i = 0; i < Slots; i++)
      send_word(arm_pkg::CMD_SET, addr_t'(i * 100 + 1), addr_t'(i * 100 + 90),
                mode_t'(i + 1));
    for (int i = 0; i < Slots; i++)
      send_word(arm_pkg::CMD_CLEAR, addr_t'(i * 100 + 40), addr_t'(i * 100 + 50), '0);
    send_word(arm_pkg::CMD_SET, addr_t'(5000), addr_t'(5001), 16'h0100);
    send_word(arm_pkg::CMD_GET, addr_t'(1), addr_t'(6000), '0);
    send_word(arm_pkg::CMD_CLEAR, addr_t'(1), '1, '0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 6; i++)
          send_word(arm_pkg::CMD_SET, addr_t'(7000 + i * 10), addr_t'(7005 + i * 10),
                    16'h0010);
        in_valid <= 0;
      end
    join
  endtask

  task automatic test_random(int n);
    logic [1:0] cmd;
    addr_t a, b;
    for (int i = 0; i < n; i++) begin
      cmd = 2'($urandom_range(0, 3));
      if (cmd == CmdBad && $urandom_range(0, 3) != 0) cmd = arm_pkg::CMD_GET;
      if ($urandom_range(0, 9) < 8) begin
        a = near_addr(); b = a + addr_t'($urandom_range(0, 20));
        if ($urandom_range(0, 19) == 0) b = near_addr();
      end else begin
        a = rand_addr(); b = rand_addr();
      end
      send_word(cmd, a, b, mode_t'($urandom()));
      if ($urandom_range(0, 39) == 0) send_word(arm_pkg::CMD_CLEAR, '0, '1, '0);
    end
    in_valid <= 0;
  endtask

  initial begin
    rst = 1; in_valid = 0; command = arm_pkg::CMD_GET; range_low = '0; range_high = '0;
    mode_bits = '0;
    for (int i = 0; i < Slots; i++) begin
      tbl_lo[i] = '0; tbl_hi[i] = '0; tbl_mode[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(490);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
